[rtl/core/four_channel_sensor_smoother_assert.svh]
// Assertion macros shared by the sensor smoother checker.
// Depends on nothing; included by the checker file.
`ifndef FOUR_CHANNEL_SENSOR_SMOOTHER_ASSERT_SVH
`define FOUR_CHANNEL_SENSOR_SMOOTHER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/core/fcs_pkg.sv]
// Package of the sensor smoother: widths, register indexes, scaling function.
// Used by every module of the block.
`timescale 1ns / 1ps
package fcs_pkg;
    localparam int CodeW = 12;
    localparam int ValW = 17;
    localparam int WeightW = 16;
    localparam int SumW = 24;
    localparam int NumLanes = 4;
    localparam int DefSampleCount = 100;
    localparam int DivSteps = 48;

    localparam int Shift4095 = 40;
    localparam logic [63:0] Recip4095 = ((64'd1 << Shift4095) + 64'd4094) / 64'd4095;
    localparam int Shift68250 = 48;
    localparam logic [63:0] Recip68250 = ((64'd1 << Shift68250) + 64'd68249) / 64'd68250;
    localparam int Shift40950 = 45;
    localparam logic [63:0] Recip40950 = ((64'd1 << Shift40950) + 64'd40949) / 64'd40950;

    localparam logic [63:0] ScvGain = 64'd16000 * Recip4095;
    localparam logic [63:0] ScvBias = 64'd2047 * Recip4095;
    localparam logic [63:0] SccGain = 64'd883712 * Recip68250;
    localparam logic [63:0] SccBias = 64'd34125 * Recip68250;
    localparam logic [63:0] FcvGain = 64'd166912 * Recip40950;
    localparam logic [63:0] FcvBias = 64'd20475 * Recip40950;
    localparam logic [63:0] FccGain = 64'd24576 * Recip4095;
    localparam logic [63:0] FccBias = 64'd2047 * Recip4095;

    typedef enum logic [2:0] {
        REG_TEMP_WEIGHT = 3'd0,
        REG_SCV_WEIGHT = 3'd1,
        REG_SCC_WEIGHT = 3'd2,
        REG_FCV_WEIGHT = 3'd3,
        REG_SCC_LIMIT = 3'd4
    } reg_idx_t;

    // Scaled value of one code, rounded as the smoothing input expects.
    function automatic logic signed [ValW-1:0] scale_code(input logic [1:0] ch,
                                                         input logic [CodeW-1:0] c);
        logic [63:0] q;
        logic signed [ValW+1:0] r;
        begin
            q = '0;
            r = '0;
            case (ch)
                2'd0:
                begin
                    q = ((64'(12'd4095 - c) * 64'd256 + 64'd7) * 64'd4473925) >> 26;
                    r = (q > 64'd65535) ? 19'sd65535 : 19'(q);
                end
                2'd1:
                begin
                    q = (64'(c) * ScvGain + ScvBias) >> Shift4095;
                    r = 19'(q);
                end
                2'd2:
                begin
                    q = (64'(c) * SccGain + SccBias) >> Shift68250;
                    r = 19'(q) - 19'sd25600;
                end
                default:
                begin
                    q = (64'(c) * FcvGain + FcvBias) >> Shift40950;
                    r = 19'(q);
                end
            endcase
            scale_code = r[ValW-1:0];
        end
    endfunction
endpackage

[rtl/core/fcs_if.sv]
// Valid/ready channel interfaces for the sensor smoother.
// Depends on fcs_pkg.
`timescale 1ns / 1ps
interface fcs_in_if import fcs_pkg::*; ();
    logic valid;
    logic ready;
    logic [CodeW-1:0] temp_code;
    logic [CodeW-1:0] sc_voltage_code;
    logic [CodeW-1:0] fc_voltage_code;
    logic [CodeW-1:0] sc_current_code;
    logic [CodeW-1:0] fc_current_code;
    logic fc_current_ready;
    modport source (output valid, temp_code, sc_voltage_code, fc_voltage_code,
                    sc_current_code, fc_current_code, fc_current_ready, input ready);
    modport sink (input valid, temp_code, sc_voltage_code, fc_voltage_code,
                  sc_current_code, fc_current_code, fc_current_ready, output ready);
endinterface

interface fcs_out_if import fcs_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [ValW-1:0] temperature;
    logic signed [ValW-1:0] sc_voltage;
    logic signed [ValW-1:0] sc_current;
    logic signed [ValW-1:0] fc_voltage;
    logic signed [ValW-1:0] fc_current;
    logic fc_current_updated;
    logic over_current;
    modport source (output valid, temperature, sc_voltage, sc_current, fc_voltage,
                    fc_current, fc_current_updated, over_current, input ready);
    modport sink (input valid, temperature, sc_voltage, sc_current, fc_voltage,
                  fc_current, fc_current_updated, over_current, output ready);
endinterface

[rtl/core/fcs_lane.sv]
// One smoothing lane: holds the filtered value and divides by the weight serially.
// Depends on fcs_pkg.
`timescale 1ns / 1ps
module fcs_lane import fcs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [ValW-1:0] x,
    input  logic [WeightW-1:0] weight,
    output logic done,
    output logic signed [ValW-1:0] filtered
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} lane_state_t;
    lane_state_t state_reg;
    logic signed [ValW-1:0] filt_reg;
    logic [WeightW-1:0] k_reg;
    logic [DivSteps-1:0] num_reg;
    logic [WeightW:0] rem_reg;
    logic [DivSteps-1:0] quo_reg;
    logic neg_reg;
    logic [5:0] cnt_reg;
    logic done_reg;
    logic signed [ValW-1:0] x_reg;
    logic signed [40:0] prod;
    logic [40:0] mag;
    logic [WeightW:0] shifted;
    logic [WeightW:0] rem_next;
    logic ge;
    logic signed [ValW:0] res;

    always_comb
    begin
        prod = 41'(filt_reg) * $signed({25'd0, k_reg - 16'd256})
             + 41'(x_reg) * 41'sd256;
        mag = prod[40] ? 41'(-prod) : 41'(prod);
        shifted = {rem_reg[WeightW-1:0], num_reg[DivSteps-1]};
        ge = shifted >= {1'b0, k_reg};
        rem_next = ge ? shifted - {1'b0, k_reg} : shifted;
        res = neg_reg ? -$signed({1'b0, quo_reg[ValW-2:0], ge})
                      : $signed({1'b0, quo_reg[ValW-2:0], ge});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            filt_reg <= '0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_DIV) && (cnt_reg == 6'(DivSteps - 1));
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg <= x;
                        k_reg <= (weight < 16'd256) ? 16'd256 : weight;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    neg_reg <= prod[40];
                    num_reg <= {7'd0, mag} + {32'd0, k_reg >> 1};
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    num_reg <= {num_reg[DivSteps-2:0], 1'b0};
                    quo_reg <= {quo_reg[DivSteps-2:0], ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DivSteps - 1))
                    begin
                        filt_reg <= res[ValW-1:0];
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign filtered = filt_reg;
endmodule

[rtl/core/fcs_block_avg.sv]
// Latches, sums and block-averages the cell current channel.
// Depends on fcs_pkg.
`timescale 1ns / 1ps
module fcs_block_avg import fcs_pkg::*; #(
    parameter int SAMPLE_COUNT = DefSampleCount
) (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic [CodeW-1:0] code,
    input  logic code_ready,
    output logic signed [ValW-1:0] value,
    output logic updated
);
    localparam int AvgShift = 33;
    localparam logic [63:0] AvgRecip =
        ((64'd1 << AvgShift) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);

    logic [CodeW-1:0] latch_reg;
    logic [SumW-1:0] sum_reg;
    logic [7:0] count_reg;
    logic signed [ValW-1:0] value_reg;
    logic updated_reg;
    logic [CodeW-1:0] avg_reg;
    logic calc_reg;
    logic [CodeW-1:0] lc;
    logic [SumW-1:0] sum_new;
    logic [7:0] cnt_new;
    logic block_end;
    logic [63:0] avg;
    logic [63:0] scaled;
    logic signed [ValW+1:0] v;

    always_comb
    begin
        lc = code_ready ? code : latch_reg;
        sum_new = sum_reg + SumW'(lc);
        cnt_new = count_reg + 8'd1;
        block_end = cnt_new >= 8'(SAMPLE_COUNT);
        avg = (64'(sum_new) * AvgRecip) >> AvgShift;
        scaled = (64'(avg_reg) * FccGain + FccBias) >> Shift4095;
        v = 19'(scaled) - 19'sd12288;
        if (v > 19'sd65535)
        begin
            v = 19'sd65535;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg <= '0;
            sum_reg <= '0;
            count_reg <= '0;
            value_reg <= '0;
            updated_reg <= 1'b0;
            avg_reg <= '0;
            calc_reg <= 1'b0;
        end
        else
        begin
            calc_reg <= step && block_end;
            if (calc_reg)
            begin
                value_reg <= v[ValW-1:0];
            end
            if (step)
            begin
                latch_reg <= lc;
                if (block_end)
                begin
                    sum_reg <= '0;
                    count_reg <= '0;
                    avg_reg <= avg[CodeW-1:0];
                    updated_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_new;
                    count_reg <= cnt_new;
                    updated_reg <= 1'b0;
                end
            end
        end
    end

    assign value = value_reg;
    assign updated = updated_reg;
endmodule

[rtl/core/four_channel_sensor_smoother.sv]
// Sensor smoother top level: four smoothing lanes, block averager, APB registers.
// One item is in flight at a time; for each item the serial weight division in
// each lane (48 steps) runs before the result is offered.
// A new beat is taken once the previous result has been delivered.
// Reset (rst_n, asynchronous) clears filters, sums and registers to defaults.
`timescale 1ns / 1ps
module four_channel_sensor_smoother import fcs_pkg::*; #(
    parameter int SAMPLE_COUNT = DefSampleCount
) (
    input  logic clk,
    input  logic rst_n,
    fcs_in_if.sink in_ch,
    fcs_out_if.source out_ch,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    typedef enum logic [1:0] {T_IDLE, T_BUSY, T_OUT} top_state_t;
    top_state_t state_reg;
    logic [WeightW-1:0] weight_reg [NumLanes];
    logic signed [ValW-1:0] limit_reg;
    logic signed [ValW-1:0] x_lane [NumLanes];
    logic signed [ValW-1:0] filt [NumLanes];
    logic [NumLanes-1:0] done;
    logic start;
    logic signed [ValW-1:0] fc_val;
    logic fc_upd;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign idx = reg_idx_t'(paddr[4:2]);
    assign start = in_ch.valid && in_ch.ready;
    assign in_ch.ready = state_reg == T_IDLE;

    always_comb
    begin
        x_lane[0] = scale_code(2'd0, in_ch.temp_code);
        x_lane[1] = scale_code(2'd1, in_ch.sc_voltage_code);
        x_lane[2] = scale_code(2'd2, in_ch.sc_current_code);
        x_lane[3] = scale_code(2'd3, in_ch.fc_voltage_code);
        case (idx)
            REG_TEMP_WEIGHT: prdata = 32'(weight_reg[0]);
            REG_SCV_WEIGHT: prdata = 32'(weight_reg[1]);
            REG_SCC_WEIGHT: prdata = 32'(weight_reg[2]);
            REG_FCV_WEIGHT: prdata = 32'(weight_reg[3]);
            REG_SCC_LIMIT: prdata = 32'(limit_reg);
            default: prdata = '0;
        endcase
    end

    for (genvar i = 0; i < NumLanes; i++)
    begin : g_lane
        fcs_lane u_lane (
            .clk(clk), .rst_n(rst_n), .start(start), .x(x_lane[i]),
            .weight(weight_reg[i]), .done(done[i]), .filtered(filt[i])
        );
    end

    fcs_block_avg #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_avg (
        .clk(clk), .rst_n(rst_n), .step(start), .code(in_ch.fc_current_code),
        .code_ready(in_ch.fc_current_ready), .value(fc_val), .updated(fc_upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            weight_reg[0] <= 16'd65280;
            weight_reg[1] <= 16'd25344;
            weight_reg[2] <= 16'd1475;
            weight_reg[3] <= 16'd25344;
            limit_reg <= 17'sd2560;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (idx)
                    REG_TEMP_WEIGHT: weight_reg[0] <= pwdata[15:0];
                    REG_SCV_WEIGHT: weight_reg[1] <= pwdata[15:0];
                    REG_SCC_WEIGHT: weight_reg[2] <= pwdata[15:0];
                    REG_FCV_WEIGHT: weight_reg[3] <= pwdata[15:0];
                    REG_SCC_LIMIT: limit_reg <= pwdata[16:0];
                    default: ;
                endcase
            end
            case (state_reg)
                T_IDLE: if (start) state_reg <= T_BUSY;
                T_BUSY: if (&done) state_reg <= T_OUT;
                T_OUT: if (out_ch.ready) state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign out_ch.valid = state_reg == T_OUT;
    assign out_ch.temperature = filt[0];
    assign out_ch.sc_voltage = filt[1];
    assign out_ch.sc_current = filt[2];
    assign out_ch.fc_voltage = filt[3];
    assign out_ch.fc_current = fc_val;
    assign out_ch.fc_current_updated = fc_upd;
    assign out_ch.over_current = filt[2] >= limit_reg;
endmodule

[rtl/core/fcs_checker.sv]
// Port-level checker of the sensor smoother, bound to the top level.
// Depends on fcs_pkg and four_channel_sensor_smoother_assert.svh.
`timescale 1ns / 1ps
`include "four_channel_sensor_smoother_assert.svh"
module fcs_checker import fcs_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic pready
);
    `FCS_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready)
    `FCS_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready)
    `FCS_ASSERT_NEXT(a_acc_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
    `FCS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind four_channel_sensor_smoother fcs_checker u_fcs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .pready(pready)
);

[verif/tb_top.sv]
// Self-checking testbench for four_channel_sensor_smoother: random sample sets are sent
// under bursty input and stalling output, and every result is checked against a predictor.
// Depends on fcs_pkg, fcs_in_if, fcs_out_if and the smoother RTL.
`timescale 1ns / 1ps
module tb_top;
    import fcs_pkg::*;

    localparam logic [2:0] RegUnused = 3'd5;
    localparam logic [2:0] RegTopUnused = 3'd7;

    typedef struct {
        logic [CodeW-1:0] temp_code;
        logic [CodeW-1:0] sc_voltage_code;
        logic [CodeW-1:0] fc_voltage_code;
        logic [CodeW-1:0] sc_current_code;
        logic [CodeW-1:0] fc_current_code;
        logic fc_current_ready;
    } sample_t;

    typedef struct {
        logic signed [ValW-1:0] temperature;
        logic signed [ValW-1:0] sc_voltage;
        logic signed [ValW-1:0] sc_current;
        logic signed [ValW-1:0] fc_voltage;
        logic signed [ValW-1:0] fc_current;
        logic fc_current_updated;
        logic over_current;
    } reading_t;

    class smoother_scoreboard;
        int unsigned lane_weight[NumLanes];
        logic signed [ValW-1:0] current_limit;
        longint lane_value[NumLanes];
        logic [CodeW-1:0] held_code;
        logic [SumW-1:0] code_sum;
        logic [7:0] code_count;
        longint block_current;
        reading_t expected_q[$];
        int errors;

        function new();
            lane_weight = '{65280, 25344, 1475, 25344};
            current_limit = 17'sd2560;
            foreach (lane_value[i])
            begin
                lane_value[i] = 0;
            end
            held_code = '0;
            code_sum = '0;
            code_count = '0;
            block_current = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_TEMP_WEIGHT: lane_weight[0] = 32'(value[15:0]);
                REG_SCV_WEIGHT: lane_weight[1] = 32'(value[15:0]);
                REG_SCC_WEIGHT: lane_weight[2] = 32'(value[15:0]);
                REG_FCV_WEIGHT: lane_weight[3] = 32'(value[15:0]);
                REG_SCC_LIMIT: current_limit = value[ValW-1:0];
                default: ;
            endcase
        endfunction

        function longint ema(longint prev, longint x, int unsigned w);
            longint k;
            longint num;
            k = (w < 256) ? 256 : w;
            num = prev * (k - 256) + x * 256;
            if (num >= 0)
                return (num + k / 2) / k;
            return -((-num + k / 2) / k);
        endfunction

        function void note_sample(sample_t s);
            reading_t r;
            longint scaled[NumLanes];
            longint mean;
            r.fc_current_updated = 1'b0;
            if (s.fc_current_ready)
                held_code = s.fc_current_code;
            code_sum = code_sum + SumW'(held_code);
            code_count = code_count + 8'd1;
            if (code_count >= DefSampleCount)
            begin
                mean = code_sum / DefSampleCount;
                block_current = (mean * 24576 + 2047) / 4095 - 12288;
                if (block_current > 65535)
                    block_current = 65535;
                code_sum = '0;
                code_count = '0;
                r.fc_current_updated = 1'b1;
            end
            scaled[0] = ((4095 - longint'(s.temp_code)) * 256 + 7) / 15;
            if (scaled[0] > 65535)
                scaled[0] = 65535;
            scaled[1] = (longint'(s.sc_voltage_code) * 16000 + 2047) / 4095;
            scaled[2] = (longint'(s.sc_current_code) * 5302272 + 204750) / 409500 - 25600;
            scaled[3] = (longint'(s.fc_voltage_code) * 166912 + 20475) / 40950;
            foreach (lane_value[i])
            begin
                lane_value[i] = ema(lane_value[i], scaled[i], lane_weight[i]);
            end
            r.temperature = ValW'(lane_value[0]);
            r.sc_voltage = ValW'(lane_value[1]);
            r.sc_current = ValW'(lane_value[2]);
            r.fc_voltage = ValW'(lane_value[3]);
            r.fc_current = ValW'(block_current);
            r.over_current = (lane_value[2] >= longint'(current_limit));
            expected_q.push_back(r);
        endfunction

        function void check_result(reading_t a);
            reading_t e;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no expected result waiting");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.temperature !== e.temperature)
            begin
                $error("temperature: expected %0d, got %0d", e.temperature, a.temperature);
                errors++;
            end
            if (a.sc_voltage !== e.sc_voltage)
            begin
                $error("sc_voltage: expected %0d, got %0d", e.sc_voltage, a.sc_voltage);
                errors++;
            end
            if (a.sc_current !== e.sc_current)
            begin
                $error("sc_current: expected %0d, got %0d", e.sc_current, a.sc_current);
                errors++;
            end
            if (a.fc_voltage !== e.fc_voltage)
            begin
                $error("fc_voltage: expected %0d, got %0d", e.fc_voltage, a.fc_voltage);
                errors++;
            end
            if (a.fc_current !== e.fc_current)
            begin
                $error("fc_current: expected %0d, got %0d", e.fc_current, a.fc_current);
                errors++;
            end
            if (a.fc_current_updated !== e.fc_current_updated)
            begin
                $error("fc_current_updated: expected %0b, got %0b",
                       e.fc_current_updated, a.fc_current_updated);
                errors++;
            end
            if (a.over_current !== e.over_current)
            begin
                $error("over_current: expected %0b, got %0b", e.over_current, a.over_current);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    int hold_requests;

    fcs_in_if in_ch ();
    fcs_out_if out_ch ();

    smoother_scoreboard sb;

    four_channel_sensor_smoother uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    // Result side: stretches of differing stall density, plus a long hold-off on request.
    initial
    begin
        int stretch;
        int mode;
        int hold_left;
        int seen_requests;
        out_ch.ready = 1'b0;
        stretch = 0;
        mode = 0;
        hold_left = 0;
        seen_requests = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != seen_requests)
            begin
                seen_requests = hold_requests;
                hold_left = 800;
            end
            if (stretch == 0)
            begin
                stretch = $urandom_range(1, 64);
                mode = $urandom_range(0, 2);
            end
            stretch--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                out_ch.ready <= 1'b1;
            else if (mode == 1)
                out_ch.ready <= $urandom_range(0, 1);
            else
                out_ch.ready <= ($urandom_range(0, 7) == 0);
        end
    end

    always @(posedge clk)
    begin
        reading_t r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            r.temperature = out_ch.temperature;
            r.sc_voltage = out_ch.sc_voltage;
            r.sc_current = out_ch.sc_current;
            r.fc_voltage = out_ch.fc_voltage;
            r.fc_current = out_ch.fc_current;
            r.fc_current_updated = out_ch.fc_current_updated;
            r.over_current = out_ch.over_current;
            sb.check_result(r);
        end
    end

    task automatic send_sample(sample_t s);
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.temp_code <= s.temp_code;
        in_ch.sc_voltage_code <= s.sc_voltage_code;
        in_ch.fc_voltage_code <= s.fc_voltage_code;
        in_ch.sc_current_code <= s.sc_current_code;
        in_ch.fc_current_code <= s.fc_current_code;
        in_ch.fc_current_ready <= s.fc_current_ready;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(s);
    endtask

    task automatic idle_input(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    task automatic drain();
        idle_input(1);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_weights(int unsigned w0, int unsigned w1, int unsigned w2,
                               int unsigned w3, int limit);
        apb_write(REG_TEMP_WEIGHT, w0);
        apb_write(REG_SCV_WEIGHT, w1);
        apb_write(REG_SCC_WEIGHT, w2);
        apb_write(REG_FCV_WEIGHT, w3);
        apb_write(REG_SCC_LIMIT, 32'(limit));
    endtask

    function automatic logic [CodeW-1:0] pick_code();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CodeW'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.temp_code = pick_code();
        s.sc_voltage_code = pick_code();
        s.fc_voltage_code = pick_code();
        s.sc_current_code = pick_code();
        s.fc_current_code = pick_code();
        s.fc_current_ready = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic sample_t flat_sample(logic [CodeW-1:0] c, logic rdy);
        sample_t s;
        s.temp_code = c;
        s.sc_voltage_code = c;
        s.fc_voltage_code = c;
        s.sc_current_code = c;
        s.fc_current_code = c;
        s.fc_current_ready = rdy;
        return s;
    endfunction

    task automatic random_run(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 30);
            if (burst > left)
                burst = left;
            if ($urandom_range(0, 9) == 0)
                hold_requests++;
            repeat (burst)
                send_sample(random_sample());
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 40));
        end
    endtask

    initial
    begin
        sb = new();
        hold_requests = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.temp_code = '0;
        in_ch.sc_voltage_code = '0;
        in_ch.fc_voltage_code = '0;
        in_ch.sc_current_code = '0;
        in_ch.fc_current_code = '0;
        in_ch.fc_current_ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_sample(flat_sample(12'd0, 1'b1));
        send_sample(flat_sample(12'd4095, 1'b0));
        send_sample(flat_sample(12'd4095, 1'b1));
        send_sample(flat_sample(12'd0, 1'b0));
        send_sample(flat_sample(12'd2048, 1'b1));
        send_sample(flat_sample(12'd1, 1'b0));
        random_run(150);
        drain();

        // Weights at or below one behave as no smoothing; the lowest limit goes with them.
        set_weights(0, 255, 256, 1, -65536);
        send_sample(flat_sample(12'd0, 1'b1));
        send_sample(flat_sample(12'd4095, 1'b1));
        send_sample(flat_sample(12'd0, 1'b0));
        send_sample(flat_sample(12'd4094, 1'b1));
        random_run(200);
        drain();

        set_weights(65535, 65535, 65535, 65535, 65535);
        send_sample(flat_sample(12'd4095, 1'b1));
        send_sample(flat_sample(12'd0, 1'b1));
        random_run(250);
        drain();

        // Writes to addresses beyond the register list must change nothing.
        apb_write(RegUnused, 32'h0000_0100);
        apb_write(RegTopUnused, 32'hFFFF_FFFF);
        set_weights(256, 300, 1475, 512, 0);
        random_run(200);
        hold_requests++;
        random_run(100);
        drain();

        repeat (3)
        begin
            set_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(200, 4000), $urandom_range(0, 65535),
                        $urandom_range(0, 131071) - 65536);
            random_run(170);
            drain();
        end

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
